// ===== hw/rtl/drpm_pkg.sv =====
package drpm_pkg;

    localparam int RINGS_DEF = 64;
    localparam int DIV_W     = 33;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_ZERO  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_POP   = 1'b1;

    localparam logic [4:0] REG_BASE_LO = 5'd0;
    localparam logic [4:0] REG_BASE_HI = 5'd1;
    localparam logic [4:0] REG_ENTRY   = 5'd2;
    localparam logic [4:0] REG_THRESH  = 5'd3;
    localparam logic [4:0] REG_LEVEL   = 5'd4;
    localparam logic [4:0] REG_WB_LO   = 5'd5;
    localparam logic [4:0] REG_WB_HI   = 5'd6;
    localparam logic [4:0] REG_FLAGS   = 5'd7;

    // Group 1 register that holds the driver-side pointer.
    localparam logic [4:0] REG_DRV_PTR = 5'd0;

    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [31:0] value;
        logic [5:0]  pop_ring;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] fetch_addr;
        logic [9:0]  fetch_bytes;
        logic [19:0] tail_value;
        logic [63:0] tail_write_addr;
        logic [5:0]  ring_out;
    } t_rsp;

    // Handshake between the sequencer and the shared divider.
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [19:0]       divisor;
    } t_div_cmd;

    typedef struct packed {
        logic        done;
        logic [19:0] remainder;
        logic [19:0] quotient;
    } t_div_rsp;

endpackage

// ===== hw/rtl/drpm_if.sv =====
interface drpm_req_if;
    import drpm_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface drpm_rsp_if;
    import drpm_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/drpm_div.sv =====
module drpm_div
    import drpm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_cmd i_cmd,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo;
    logic [20:0]      r_rem;
    logic [19:0]      r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [20:0]      w_shift;
    logic [20:0]      w_diff;

    // Restoring division, one quotient bit per cycle.
    assign w_shift = {r_rem[19:0], r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CW'(DIV_W);
                r_quo  <= i_cmd.dividend;
                r_rem  <= '0;
                r_dvs  <= i_cmd.divisor;
            end else if (r_busy) begin
                if (!w_diff[20]) begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
                r_cnt  <= r_cnt - 1'b1;
                r_busy <= (r_cnt != CW'(1));
                r_done <= (r_cnt == CW'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem[19:0];
    assign o_rsp.quotient  = r_quo[19:0];

endmodule

// ===== hw/rtl/descriptor_ring_pointer_manager_top.sv =====
// Channel   Dir  Handshake      Word
// i_req     in   valid/ready    kind, addr, value, pop_ring
// o_rsp     out  valid/ready    status, fetch_addr, fetch_bytes, tail_value,
//                               tail_write_addr, ring_out
// i_cfg_we  in   write enable   dst_ring_map (64 bits)
//
// One word is handled at a time. A simple write or a failing pop has its result
// registered through S_READ and S_EXEC and valid in S_RESP.
// An entry-size or threshold write and a good pop wait for the 33-step serial
// divider shared by the entry-count quotient, batch quotient and tail-wrap
// remainder; the result is valid in S_RESP once S_DIVWAIT sees the divider done.
// Reset is synchronous and active low. After reset a clearing pass zeroes one
// ring entry per cycle across all RINGS entries (64 by default) before the first word
// is accepted. A stalled result holds until taken, and no new word is accepted
// until then.
module descriptor_ring_pointer_manager_top
    import drpm_pkg::*;
#(
    parameter int RINGS = RINGS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [63:0]   i_cfg_wdata,
    drpm_req_if.sink      i_req,
    drpm_rsp_if.source    o_rsp
);

    localparam int RW = (RINGS > 1) ? $clog2(RINGS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIVWAIT, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        OP_COUNT, OP_BATCH, OP_WRAP
    } t_divop;

    // Ring tables. They are written at one ring per cycle and read into the
    // snapshot registers below in S_READ, the state before S_EXEC uses the entry.
    logic [39:0] r_base  [RINGS];
    logic [19:0] r_rwords[RINGS];
    logic [7:0]  r_ewords[RINGS];
    logic [19:0] r_ecount[RINGS];
    logic [15:0] r_timer [RINGS];
    logic [14:0] r_batch [RINGS];
    logic [15:0] r_level [RINGS];
    logic [63:0] r_wb    [RINGS];
    logic [31:0] r_dev   [RINGS];
    logic [31:0] r_drv   [RINGS];
    logic        r_dst   [RINGS];
    logic [31:0] r_flags [RINGS];
    logic [RW-1:0] r_clr;

    logic [63:0] r_map;
    t_state      r_state;
    t_req        r_req;
    t_rsp        r_rsp;
    logic [RW-1:0] r_ring;
    logic        r_inrange;
    t_divop      r_divop;

    // Snapshot of the addressed ring, read in S_READ.
    logic [39:0] r_s_base;
    logic [19:0] r_s_rwords;
    logic [7:0]  r_s_ewords;
    logic [63:0] r_s_wb;
    logic [31:0] r_s_dev;
    logic [31:0] r_s_drv;
    logic        r_s_dst;

    t_div_cmd r_dcmd;
    t_div_rsp w_drsp;

    t_status    n_status;
    t_divop     n_divop;
    t_div_cmd   n_dcmd;
    logic [5:0] n_ring_out;

    logic [7:0] w_rid;
    logic       w_grp;
    logic [4:0] w_reg;

    assign w_rid = r_req.addr[15:8];
    assign w_grp = r_req.addr[7];
    assign w_reg = r_req.addr[6:2];

    drpm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (r_dcmd),
        .o_rsp  (w_drsp)
    );

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = (r_state == S_RESP);
    assign o_rsp.payload = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
        end else if (i_cfg_we) begin
            r_map   <= i_cfg_wdata;
        end
    end

    // Decision for the word in S_EXEC, taken from the snapshot of its ring.
    // A pop checks direction first, then emptiness, then a zero ring size.
    assign n_ring_out = (r_req.kind == KIND_WRITE) ? w_rid[5:0] : r_req.pop_ring;

    always_comb begin
        n_status = ST_OK;
        n_divop  = OP_COUNT;
        n_dcmd   = '0;
        if (!r_inrange) begin
            n_status = ST_BAD;
        end else if (r_req.kind == KIND_WRITE) begin
            if (!w_grp) begin
                case (w_reg)
                    REG_ENTRY: begin
                        if (r_req.value[7:0] == 8'd0) begin
                            n_status = ST_ZERO;
                        end else begin
                            n_dcmd.start    = 1'b1;
                            n_dcmd.dividend = DIV_W'(r_s_rwords);
                            n_dcmd.divisor  = {12'd0, r_req.value[7:0]};
                            n_divop         = OP_COUNT;
                        end
                    end
                    REG_THRESH: begin
                        if (r_s_ewords == 8'd0) begin
                            n_status = ST_ZERO;
                        end else begin
                            n_dcmd.start    = 1'b1;
                            n_dcmd.dividend = DIV_W'(r_req.value[14:0]);
                            n_dcmd.divisor  = {12'd0, r_s_ewords};
                            n_divop         = OP_BATCH;
                        end
                    end
                    REG_BASE_LO, REG_BASE_HI, REG_LEVEL, REG_WB_LO, REG_WB_HI,
                    REG_FLAGS: begin
                    end
                    default: n_status = ST_BAD;
                endcase
            end
        end else if (r_s_dst) begin
            n_status = ST_BAD;
        end else if (r_s_dev == r_s_drv) begin
            n_status = ST_EMPTY;
        end else if (r_s_rwords == 20'd0) begin
            n_status = ST_ZERO;
        end else begin
            n_dcmd.start    = 1'b1;
            n_dcmd.dividend = {1'b0, r_s_dev} + {25'd0, r_s_ewords};
            n_dcmd.divisor  = r_s_rwords;
            n_divop         = OP_WRAP;
        end
    end

    // The divider command is a one-cycle start pulse issued from S_EXEC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcmd <= '0;
        end else if (r_state == S_EXEC) begin
            r_dcmd <= n_dcmd;
        end else begin
            r_dcmd.start <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_base[r_clr]   <= '0;
                    r_rwords[r_clr] <= '0;
                    r_ewords[r_clr] <= '0;
                    r_ecount[r_clr] <= '0;
                    r_timer[r_clr]  <= '0;
                    r_batch[r_clr]  <= '0;
                    r_level[r_clr]  <= '0;
                    r_wb[r_clr]     <= '0;
                    r_dev[r_clr]    <= '0;
                    r_drv[r_clr]    <= '0;
                    r_dst[r_clr]    <= 1'b0;
                    r_flags[r_clr]  <= '0;
                    r_clr           <= r_clr + 1'b1;
                    if (r_clr == RW'(RINGS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.payload;
                        if (i_req.payload.kind == KIND_WRITE) begin
                            r_inrange <= ({1'b0, i_req.payload.addr[15:8]} < 9'(RINGS));
                            r_ring    <= RW'(i_req.payload.addr[15:8]);
                        end else begin
                            r_inrange <= ({1'b0, i_req.payload.pop_ring} < 7'(RINGS));
                            r_ring    <= RW'(i_req.payload.pop_ring);
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_s_base   <= r_base[r_ring];
                    r_s_rwords <= r_rwords[r_ring];
                    r_s_ewords <= r_ewords[r_ring];
                    r_s_wb     <= r_wb[r_ring];
                    r_s_dev    <= r_dev[r_ring];
                    r_s_drv    <= r_drv[r_ring];
                    r_s_dst    <= r_dst[r_ring];
                    r_state    <= S_EXEC;
                end
                S_EXEC: begin
                    r_rsp   <= t_rsp'({n_status, 158'd0, n_ring_out});
                    r_divop <= n_divop;
                    r_state <= n_dcmd.start ? S_DIVWAIT : S_RESP;
                    if (r_inrange && r_req.kind == KIND_WRITE) begin
                        if (w_grp) begin
                            if (w_reg == REG_DRV_PTR)
                                r_drv[r_ring] <= r_req.value;
                        end else begin
                            case (w_reg)
                                REG_BASE_LO: begin
                                    r_base[r_ring] <= {8'd0, r_req.value};
                                    r_dst[r_ring]  <= r_map[r_ring];
                                end
                                REG_BASE_HI: begin
                                    r_base[r_ring][39:32] <= r_req.value[7:0];
                                    r_rwords[r_ring] <= r_req.value[27:8];
                                end
                                REG_ENTRY:  r_ewords[r_ring] <= r_req.value[7:0];
                                REG_THRESH: r_timer[r_ring]  <= r_req.value[31:16];
                                REG_LEVEL:  r_level[r_ring]  <= r_req.value[15:0];
                                REG_WB_LO:  r_wb[r_ring]     <= {32'd0, r_req.value};
                                REG_WB_HI: begin
                                    r_wb[r_ring][63:32] <= r_req.value;
                                    r_dev[r_ring] <= '0;
                                end
                                REG_FLAGS:  r_flags[r_ring]  <= r_req.value;
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                S_DIVWAIT: begin
                    if (w_drsp.done) begin
                        r_state <= S_RESP;
                        case (r_divop)
                            OP_COUNT: r_ecount[r_ring] <= w_drsp.quotient;
                            OP_BATCH: r_batch[r_ring]  <= w_drsp.quotient[14:0];
                            default: begin
                                r_dev[r_ring] <= {12'd0, w_drsp.remainder};
                                r_rsp <= t_rsp'({r_rsp.status,
                                                 {24'd0, r_s_base} + {30'd0, r_s_dev, 2'b00},
                                                 r_s_ewords, 2'b00,
                                                 w_drsp.remainder,
                                                 r_s_wb,
                                                 r_rsp.ring_out});
                            end
                        endcase
                    end
                end
                S_RESP: begin
                    if (o_rsp.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready)
        else $error("word accepted while busy");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> o_rsp.valid && $stable(r_rsp))
        else $error("result dropped under stall");
    a_div_only_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.done |-> (r_state == S_DIVWAIT))
        else $error("divider finished outside wait");
`endif

endmodule

// ===== sim/descriptor_ring_pointer_manager_top_tb.sv =====
`timescale 1ns / 1ps

// Checks the descriptor ring pointer manager against a per-ring software
// copy of its tables. A directed table comes first: writes and pops that hit
// reset state, bad rings and registers, zero sizes, empty rings, destination
// rings and an all-ones source ring. A constrained-by-hand random mix
// follows that mostly programs small rings and pops them.
module descriptor_ring_pointer_manager_top_tb;
    import drpm_pkg::*;

    localparam int NRING = 64;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [63:0] i_cfg_wdata = '0;

    always #4 i_clk = ~i_clk;

    drpm_req_if req_ch ();
    drpm_rsp_if rsp_ch ();

    descriptor_ring_pointer_manager_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    // Software copy of the ring tables.
    logic [63:0] dst_map;
    logic [39:0] ring_base [NRING];
    logic [19:0] ring_len [NRING];
    logic [7:0]  ent_len [NRING];
    logic [63:0] wb_addr [NRING];
    logic [31:0] tail_ptr [NRING];
    logic [31:0] head_ptr [NRING];
    logic        is_dst [NRING];

    t_rsp pending_rsp [$];
    int   error_count = 0;
    int   quiet_cycles = 0;
    bit   no_idle = 1'b0;
    bit   hold_off = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    function automatic t_rsp predict_ring_op(input t_req rq);
        t_rsp rs;
        logic [7:0] rid;
        logic [5:0] ri;
        logic [4:0] regn;
        logic [5:0] pr;
        logic [63:0] nxt;
        rs = '0;
        if (rq.kind == KIND_WRITE) begin
            rid = rq.addr[15:8];
            ri = rid[5:0];
            regn = rq.addr[6:2];
            rs.ring_out = rid[5:0];
            if (rid >= NRING) begin
                rs.status = ST_BAD;
            end else if (rq.addr[7]) begin
                if (regn == REG_DRV_PTR) head_ptr[ri] = rq.value;
            end else begin
                case (regn)
                    REG_BASE_LO: begin
                        ring_base[ri] = {8'h0, rq.value};
                        is_dst[ri] = dst_map[ri];
                    end
                    REG_BASE_HI: begin
                        ring_base[ri][39:32] = rq.value[7:0];
                        ring_len[ri] = rq.value[27:8];
                    end
                    REG_ENTRY: begin
                        ent_len[ri] = rq.value[7:0];
                        if (rq.value[7:0] == 8'd0) rs.status = ST_ZERO;
                    end
                    REG_THRESH: begin
                        if (ent_len[ri] == 8'd0) rs.status = ST_ZERO;
                    end
                    REG_LEVEL, REG_FLAGS: ;
                    REG_WB_LO: wb_addr[ri] = {32'h0, rq.value};
                    REG_WB_HI: begin
                        wb_addr[ri][63:32] = rq.value;
                        tail_ptr[ri] = '0;
                    end
                    default: rs.status = ST_BAD;
                endcase
            end
        end else begin
            pr = rq.pop_ring;
            rs.ring_out = pr;
            if (is_dst[pr]) begin
                rs.status = ST_BAD;
            end else if (tail_ptr[pr] == head_ptr[pr]) begin
                rs.status = ST_EMPTY;
            end else if (ring_len[pr] == 20'd0) begin
                rs.status = ST_ZERO;
            end else begin
                nxt = (64'(tail_ptr[pr]) + 64'(ent_len[pr])) % 64'(ring_len[pr]);
                rs.fetch_addr = 64'(ring_base[pr]) + (64'(tail_ptr[pr]) << 2);
                rs.fetch_bytes = {ent_len[pr], 2'b00};
                rs.tail_value = nxt[19:0];
                rs.tail_write_addr = wb_addr[pr];
                tail_ptr[pr] = nxt[31:0];
            end
        end
        return rs;
    endfunction

    // Response side: compare each accepted word with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected word, ring", 64'(rsp_ch.payload.ring_out), 64'd0);
            end else begin
                t_rsp w;
                w = pending_rsp.pop_front();
                if (rsp_ch.payload.status != w.status)
                    report_mismatch("status", 64'(rsp_ch.payload.status), 64'(w.status));
                if (rsp_ch.payload.fetch_addr != w.fetch_addr)
                    report_mismatch("fetch_addr", rsp_ch.payload.fetch_addr, w.fetch_addr);
                if (rsp_ch.payload.fetch_bytes != w.fetch_bytes)
                    report_mismatch("fetch_bytes", 64'(rsp_ch.payload.fetch_bytes),
                                    64'(w.fetch_bytes));
                if (rsp_ch.payload.tail_value != w.tail_value)
                    report_mismatch("tail_value", 64'(rsp_ch.payload.tail_value),
                                    64'(w.tail_value));
                if (rsp_ch.payload.tail_write_addr != w.tail_write_addr)
                    report_mismatch("tail_write_addr", rsp_ch.payload.tail_write_addr,
                                    w.tail_write_addr);
                if (rsp_ch.payload.ring_out != w.ring_out)
                    report_mismatch("ring_out", 64'(rsp_ch.payload.ring_out),
                                    64'(w.ring_out));
            end
        end
    end

    // Receiver stalls come in random bursts; a long hold-off is requested by
    // the stimulus so the block fills up and stops taking words.
    initial begin
        int gap;
        int held;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                rsp_ch.ready <= 1'b0;
                for (held = 0; held < 300; held++) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 11);
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // The watchdog counts cycles in which neither side moves a word.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("descriptor_ring_pointer_manager_top_tb NOT OK");
            $finish;
        end
    end

    // Offers one word and predicts its response once it is taken. Random
    // idle bursts go in front of the word while idling is allowed.
    task automatic send_word(input t_req rq);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= rq;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_rsp.push_back(predict_ring_op(rq));
    endtask

    // Clears valid and waits until every predicted word has arrived.
    task automatic drain_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_map(input logic [63:0] m);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dst_map = m;
    endtask

    function automatic t_req make_write(input int ring, input bit grp, input logic [4:0] regn,
                                        input logic [31:0] val);
        t_req rq;
        rq.kind = KIND_WRITE;
        rq.addr = {ring[7:0], grp, regn, 2'($urandom_range(0, 3))};
        rq.value = val;
        rq.pop_ring = 6'($urandom);
        return rq;
    endfunction

    function automatic t_req make_pop(input int ring);
        t_req rq;
        rq.kind = KIND_POP;
        rq.addr = 16'($urandom);
        rq.value = $urandom;
        rq.pop_ring = ring[5:0];
        return rq;
    endfunction

    // Directed table. A row with check set carries an expected status that
    // can be read straight off the register map.
    typedef struct {
        t_req    rq;
        bit      check;
        t_status want;
    } t_row;

    t_row dir_rows [$];

    task automatic add_row(input t_req rq, input bit check, input t_status want);
        t_row row;
        row.rq = rq;
        row.check = check;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // Programs a small source or destination ring with random content.
    task automatic setup_ring(input int r);
        send_word(make_write(r, 1'b0, REG_BASE_LO, $urandom));
        send_word(make_write(r, 1'b0, REG_BASE_HI,
                             {4'($urandom), 20'($urandom_range(0, 40)), 8'($urandom)}));
        send_word(make_write(r, 1'b0, REG_ENTRY, 32'($urandom_range(0, 9)) |
                             ($urandom & 32'hffffff00)));
        send_word(make_write(r, 1'b0, REG_THRESH, $urandom));
        send_word(make_write(r, 1'b0, REG_WB_LO, $urandom));
        send_word(make_write(r, 1'b0, REG_WB_HI, $urandom));
        send_word(make_write(r, 1'b1, REG_DRV_PTR, $urandom_range(0, 40)));
    endtask

    initial begin
        t_req rq;
        t_rsp w;
        int n;
        int r;
        int pick;
        for (int k = 0; k < NRING; k++) begin
            ring_base[k] = '0; ring_len[k] = '0; ent_len[k] = '0;
            wb_addr[k] = '0; tail_ptr[k] = '0; head_ptr[k] = '0; is_dst[k] = 1'b0;
        end
        dst_map = '0;
        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ring 5 becomes a destination ring; ring 63 an all-ones source ring.
        write_map(64'h0000_0000_0000_0020);
        add_row(make_pop(0), 1'b1, ST_EMPTY);
        add_row(make_write(64, 1'b0, REG_BASE_LO, 32'h1), 1'b1, ST_BAD);
        add_row(make_write(255, 1'b1, REG_DRV_PTR, 32'hffff_ffff), 1'b1, ST_BAD);
        add_row(make_write(3, 1'b0, 5'd8, 32'h0), 1'b1, ST_BAD);
        add_row(make_write(3, 1'b0, 5'd31, 32'hffff_ffff), 1'b1, ST_BAD);
        add_row(make_write(3, 1'b1, 5'd31, 32'h5), 1'b1, ST_OK);
        add_row(make_write(3, 1'b0, REG_THRESH, 32'hffff_ffff), 1'b1, ST_ZERO);
        add_row(make_write(3, 1'b0, REG_ENTRY, 32'hffff_ff00), 1'b1, ST_ZERO);
        add_row(make_write(3, 1'b1, REG_DRV_PTR, 32'h4), 1'b1, ST_OK);
        add_row(make_pop(3), 1'b1, ST_ZERO);
        add_row(make_write(5, 1'b0, REG_BASE_LO, 32'h1000), 1'b1, ST_OK);
        add_row(make_write(5, 1'b1, REG_DRV_PTR, 32'h2), 1'b1, ST_OK);
        add_row(make_pop(5), 1'b1, ST_BAD);
        add_row(make_write(63, 1'b0, REG_BASE_LO, 32'hffff_fffc), 1'b1, ST_OK);
        add_row(make_write(63, 1'b0, REG_BASE_HI, 32'hffff_ffff), 1'b1, ST_OK);
        add_row(make_write(63, 1'b0, REG_ENTRY, 32'h0000_00ff), 1'b1, ST_OK);
        add_row(make_write(63, 1'b0, REG_THRESH, 32'hffff_7fff), 1'b1, ST_OK);
        add_row(make_write(63, 1'b0, REG_LEVEL, 32'hffff_ffff), 1'b1, ST_OK);
        add_row(make_write(63, 1'b0, REG_WB_LO, 32'hffff_ffff), 1'b1, ST_OK);
        add_row(make_write(63, 1'b0, REG_WB_HI, 32'hffff_ffff), 1'b1, ST_OK);
        add_row(make_write(63, 1'b0, REG_FLAGS, 32'hffff_ffff), 1'b1, ST_OK);
        add_row(make_write(63, 1'b1, REG_DRV_PTR, 32'hffff_ffff), 1'b1, ST_OK);
        add_row(make_pop(63), 1'b0, ST_OK);
        add_row(make_pop(63), 1'b0, ST_OK);
        add_row(make_pop(63), 1'b0, ST_OK);

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].rq);
            if (dir_rows[i].check) begin
                w = pending_rsp[$];
                if (w.status != dir_rows[i].want)
                    report_mismatch("table status", 64'(w.status), 64'(dir_rows[i].want));
            end
        end
        drain_idle();

        // Several direction maps, the extremes among them, each with its own
        // phase of ring setup and pops. Rings are re-latched by a base write.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_map(64'h0);
                1: write_map({$urandom, $urandom});
                2: write_map(64'hffff_ffff_ffff_ffff);
                default: write_map({$urandom, $urandom} & 64'hffff_0000_ffff_0000);
            endcase
            if (phase == 1) hold_off = 1'b1;
            for (n = 0; n < 170; n++) begin
                if (phase == 3 && n > 95) no_idle = 1'b1;
                pick = $urandom_range(0, 19);
                r = $urandom_range(0, 7);
                if (pick == 0) begin
                    setup_ring(r);
                end else if (pick < 13) begin
                    send_word(make_pop(r));
                end else if (pick < 15) begin
                    send_word(make_write(r, 1'b1, REG_DRV_PTR, $urandom_range(0, 40)));
                end else if (pick == 15) begin
                    send_word(make_pop($urandom_range(0, 63)));
                end else begin
                    // Noise: any address, any value.
                    rq.kind = KIND_WRITE;
                    rq.addr = 16'($urandom);
                    if ($urandom_range(0, 1)) rq.addr[15:14] = 2'b00;
                    rq.value = $urandom;
                    rq.pop_ring = 6'($urandom);
                    send_word(rq);
                end
                if (phase == 0 && n == 85) drain_idle();
            end
            drain_idle();
        end

        if (error_count == 0) begin
            $display("descriptor_ring_pointer_manager_top_tb OK");
        end else begin
            $display("descriptor_ring_pointer_manager_top_tb NOT OK");
        end
        $finish;
    end

endmodule
